>>> src/esp_pkg.sv
package esp_pkg;

  // Fixed field widths.
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned SUM_BITS    = 40;
  localparam int unsigned ORDER_W     = 3;
  localparam int unsigned OUT_TDATA_W = ((ORDER_W + DATA_W + 7) / 8) * 8;

  // Reset value of the order register.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_ORDER_DEF  = 4;
  localparam int unsigned MAX_ITEMS_DEF  = 256;
  localparam int unsigned VALUE_BITS_DEF = 8;

endpackage

>>> src/esp_mul.sv
module esp_mul
  import esp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] res_o
);

  localparam int unsigned HW = DATA_W / 2;

  logic [DATA_W-1:0] a_q, b_q, res_q;
  logic [1:0]        step_q;
  logic              busy_q, done_q;
  logic [HW-1:0]     op_a, op_b;
  logic [DATA_W-1:0] prod;

  // Partial product select: low*low, then the two cross terms.
  always_comb begin
    case (step_q)
      2'd0: begin
        op_a = a_q[HW-1:0];
        op_b = b_q[HW-1:0];
      end
      2'd1: begin
        op_a = a_q[HW-1:0];
        op_b = b_q[DATA_W-1:HW];
      end
      default: begin
        op_a = a_q[DATA_W-1:HW];
        op_b = b_q[HW-1:0];
      end
    endcase
    prod = DATA_W'(op_a) * DATA_W'(op_b);
  end

  // Three-step product modulo 2^64.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 2'd1;
      end
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (step_q == 2'd0) begin
        res_q <= prod;
      end else begin
        res_q[DATA_W-1:HW] <= res_q[DATA_W-1:HW] + prod[HW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/esp_div.sv
module esp_div
  import esp_pkg::*;
#(
  parameter int unsigned DW = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DW-1:0]     divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] q_q;
  logic [DW-1:0]     rem_q, d_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, busy_q, done_q;
  logic [DW:0]       trial;
  logic              fits;

  // One quotient bit per cycle, restoring.
  assign trial = {rem_q, q_q[DATA_W-1]};
  assign fits  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Magnitude shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1];
      q_q   <= dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
      q_q   <= {q_q[DATA_W-2:0], fits};
    end
  end

  // Quotient truncates toward zero.
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;
  assign done_o = done_q;

endmodule

>>> src/elementary_symmetric_poly.sv
// Loading: the three-step shared 32x32 multiplier forms each power of the element in
// turn, and no new word is accepted until the last power has been summed.
// After the last word, each e_j takes j multiply-accumulate steps and then a pass
// through the bit-serial divider, and each result word is then registered for output.
// Asynchronous active-low reset clears the power sums, count, flags and order = 4.
module elementary_symmetric_poly
  import esp_pkg::*;
#(
  parameter int unsigned MAX_ORDER  = MAX_ORDER_DEF,
  parameter int unsigned MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IN_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Element stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,   // value
  input  logic                   s_axis_tlast,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // poly_index, poly_value
  output logic                   m_axis_tuser,   // overflow
  output logic                   m_axis_tlast,
  // Order register.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ORDER_W-1:0]     cfg_wdata_i
);

  localparam int unsigned JW  = $clog2(MAX_ORDER + 1);
  localparam int unsigned PIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LMUL, S_LWAIT, S_INIT, S_OUT, S_TMUL, S_TWAIT, S_DIV, S_DWAIT
  } state_e;

  state_e                state_q;
  logic [ORDER_W-1:0]    order_q;
  logic [SUM_BITS-1:0]   psum_q [MAX_ORDER];
  logic [DATA_W-1:0]     sym_q  [MAX_ORDER+1];
  logic [CW-1:0]         cnt_q;
  logic                  ovf_q, last_q;
  logic [VALUE_BITS-1:0] x_q;
  logic [DATA_W-1:0]     pw_q, acc_q;
  logic [JW-1:0]         i_q, j_q, k_q;
  logic                  out_valid_q, out_ovf_q, out_last_q;
  logic [JW-1:0]         out_idx_q;
  logic [DATA_W-1:0]     out_val_q;

  logic                  in_fire, out_free;
  logic [JW-1:0]         k_sat;
  logic [PIW-1:0]        pidx;
  logic [JW-1:0]         sidx;
  logic [DATA_W-1:0]     sym_rd, x_ext, psum_ext;
  logic                  mul_start, mul_done, div_start, div_done;
  logic [DATA_W-1:0]     mul_a, mul_b, mul_res, div_quot;
  logic                  sym_we;
  logic [JW-1:0]         sym_waddr;
  logic [DATA_W-1:0]     sym_wdata;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Requested order, saturated at the largest supported one.
  assign k_sat = (order_q > ORDER_W'(MAX_ORDER)) ? JW'(MAX_ORDER) : JW'(order_q);

  // Table indexes: power sum i-1, and e_(j-i) or e_j while emitting.
  assign pidx     = PIW'(i_q - 1'b1);
  assign sidx     = (state_q == S_OUT) ? j_q : JW'(j_q - i_q);
  assign sym_rd   = sym_q[sidx];
  assign x_ext    = {{(DATA_W-VALUE_BITS){x_q[VALUE_BITS-1]}}, x_q};
  assign psum_ext = {{(DATA_W-SUM_BITS){psum_q[pidx][SUM_BITS-1]}}, psum_q[pidx]};

  // Shared multiplier operands.
  assign mul_start = (state_q == S_LMUL) || (state_q == S_TMUL);
  assign mul_a     = (state_q == S_LMUL) ? pw_q  : sym_rd;
  assign mul_b     = (state_q == S_LMUL) ? x_ext : psum_ext;
  assign div_start = (state_q == S_DIV);

  esp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  esp_div #(
    .DW (JW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (j_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Table of e_j: e0 on entry to the Newton phase, e_j when the divider finishes.
  assign sym_we    = (state_q == S_INIT) || ((state_q == S_DWAIT) && div_done);
  assign sym_waddr = (state_q == S_INIT) ? '0 : j_q;
  assign sym_wdata = (state_q == S_INIT) ? DATA_W'(1) : div_quot;

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_q[sym_waddr] <= sym_wdata;
    end
  end

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= ORDER_RESET;
      for (int n = 0; n < MAX_ORDER; n++) begin
        psum_q[n] <= '0;
      end
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      x_q         <= '0;
      pw_q        <= '0;
      acc_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_wdata_i;
      end
      // In S_OUT the register is either held or reloaded below.
      if (m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            last_q <= s_axis_tlast;
            if (cnt_q < CW'(MAX_ITEMS)) begin
              cnt_q   <= cnt_q + 1'b1;
              x_q     <= s_axis_tdata[VALUE_BITS-1:0];
              pw_q    <= DATA_W'(1);
              i_q     <= JW'(1);
              state_q <= S_LMUL;
            end else begin
              ovf_q <= 1'b1;
              if (s_axis_tlast) begin
                state_q <= S_INIT;
              end
            end
          end
        end
        S_LMUL: begin
          state_q <= S_LWAIT;
        end
        S_LWAIT: begin
          if (mul_done) begin
            pw_q         <= mul_res;
            psum_q[pidx] <= psum_q[pidx] + mul_res[SUM_BITS-1:0];
            if (i_q == JW'(MAX_ORDER)) begin
              state_q <= last_q ? S_INIT : S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_LMUL;
            end
          end
        end
        S_INIT: begin
          k_q     <= k_sat;
          j_q     <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= j_q;
            out_val_q   <= sym_rd;
            out_ovf_q   <= ovf_q;
            out_last_q  <= (j_q == k_q);
            if (j_q == k_q) begin
              for (int n = 0; n < MAX_ORDER; n++) begin
                psum_q[n] <= '0;
              end
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              i_q     <= JW'(1);
              acc_q   <= '0;
              state_q <= S_TMUL;
            end
          end
        end
        S_TMUL: begin
          state_q <= S_TWAIT;
        end
        S_TWAIT: begin
          if (mul_done) begin
            acc_q <= i_q[0] ? (acc_q + mul_res) : (acc_q - mul_res);
            if (i_q == j_q) begin
              state_q <= S_DIV;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_TMUL;
            end
          end
        end
        S_DIV: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result word.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - ORDER_W - DATA_W)'(0), out_val_q,
                          ORDER_W'(out_idx_q)};
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tlast  = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("item count beyond limit");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_ITEMS)))
    else $error("overflow flag set before the list filled");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TMUL) |-> ((i_q != '0) && (i_q <= j_q)))
    else $error("Newton term index out of range");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && out_free) |=> m_axis_tvalid)
    else $error("result word not presented");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ((state_q == S_LWAIT) || (state_q == S_TWAIT)))
    else $error("multiplier finished outside a wait state");

endmodule

>>> bench/elementary_symmetric_poly_tb.sv
`timescale 1ns / 1ps

module elementary_symmetric_poly_tb;
  import esp_pkg::*;

  localparam int unsigned MAX_ORDER    = MAX_ORDER_DEF;
  localparam int unsigned MAX_ITEMS    = MAX_ITEMS_DEF;
  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEF;
  localparam int unsigned IN_W         = ((VALUE_BITS + 7) / 8) * 8;
  // Worst Newton pass plus all result words, with margin.
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned MAX_GAP       = 6;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } element_t;

  typedef struct {
    logic [ORDER_W-1:0] index;
    logic [DATA_W-1:0]  value;
    logic               overflow;
    logic               end_of_run;
  } poly_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [ORDER_W-1:0]     cfg_wdata_i = '0;

  elementary_symmetric_poly #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Stimulus and expected results.
  element_t   element_queue[$];
  poly_word_t poly_expected[$];
  int unsigned elements_queued = 0;
  int unsigned elements_accepted = 0;
  int unsigned mismatches = 0;

  // Per-phase pacing controls, changed only at the falling edge.
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_go = 1'b0;

  // Predictor state.
  logic signed [SUM_BITS-1:0] model_power_sums[MAX_ORDER];
  int unsigned                model_count;
  bit                         model_overflow;
  logic [ORDER_W-1:0]         model_order;

  // Accumulate one element; on the last one, run Newton's identities and queue e0..ek.
  function automatic void take_element(logic [VALUE_BITS-1:0] value, logic last);
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] pw;
    logic signed [DATA_W-1:0] ps;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] term;
    logic signed [DATA_W-1:0] e[MAX_ORDER+1];
    int unsigned k;
    poly_word_t w;
    x = DATA_W'($signed(value));
    if (model_count < MAX_ITEMS) begin
      pw = 1;
      for (int i = 0; i < MAX_ORDER; i++) begin
        pw = pw * x;
        model_power_sums[i] = model_power_sums[i] + pw[SUM_BITS-1:0];
      end
      model_count++;
    end else begin
      model_overflow = 1'b1;
    end
    if (!last) return;
    // Orders past the top saturate.
    k = (model_order > MAX_ORDER) ? MAX_ORDER : model_order;
    e[0] = 1;
    for (int j = 1; j <= k; j++) begin
      acc = 0;
      for (int i = 1; i <= j; i++) begin
        ps = DATA_W'(model_power_sums[i-1]);
        term = e[j-i] * ps;
        acc = (i % 2 == 1) ? acc + term : acc - term;
      end
      e[j] = acc / j;
    end
    for (int j = 0; j <= k; j++) begin
      w.index = ORDER_W'(j);
      w.value = e[j];
      w.overflow = model_overflow;
      w.end_of_run = (j == k);
      poly_expected.push_back(w);
    end
    for (int i = 0; i < MAX_ORDER; i++) model_power_sums[i] = '0;
    model_count = 0;
    model_overflow = 1'b0;
  endfunction

  // Element driver: one draw of the idle gap per element.
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    element_t el;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      src_gap <= 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (element_queue.size() > 0) begin
        el = element_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(el.value);
        s_axis_tlast <= el.last;
        src_gap <= src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here and only once.
  logic        sink_hold = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_count = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_count <= 0;
    end else if (hold_go && !hold_done) begin
      if (hold_count < HOLD_CYCLES) begin
        sink_hold <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        sink_hold <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  // Result receiver: a fresh stall length after every accepted word.
  int unsigned sink_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      w = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      sink_wait <= w;
      m_axis_tready <= (w == 0);
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: track register writes, predict accepted elements, check result words.
  always @(posedge clk_i or negedge rst_ni) begin
    poly_word_t w;
    bit bad;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) model_power_sums[i] = '0;
      model_count = 0;
      model_overflow = 1'b0;
      model_order = ORDER_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) model_order = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        take_element(s_axis_tdata[VALUE_BITS-1:0], s_axis_tlast);
        elements_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (poly_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: index %0d value %0d ovf %0b last %0b",
                     m_axis_tdata[ORDER_W-1:0],
                     $signed(m_axis_tdata[ORDER_W+DATA_W-1:ORDER_W]),
                     m_axis_tuser, m_axis_tlast);
        end else begin
          w = poly_expected.pop_front();
          bad = (m_axis_tdata[ORDER_W-1:0] !== w.index)
             || (m_axis_tdata[ORDER_W+DATA_W-1:ORDER_W] !== w.value)
             || (m_axis_tuser !== w.overflow)
             || (m_axis_tlast !== w.end_of_run);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp e%0d=%0d ovf %0b last %0b, got e%0d=%0d ovf %0b last %0b",
                       w.index, $signed(w.value), w.overflow, w.end_of_run,
                       m_axis_tdata[ORDER_W-1:0],
                       $signed(m_axis_tdata[ORDER_W+DATA_W-1:ORDER_W]),
                       m_axis_tuser, m_axis_tlast);
          end
        end
      end
    end
  end

  function automatic void push_element(logic [VALUE_BITS-1:0] value, logic last);
    element_t el;
    el.value = value;
    el.last = last;
    element_queue.push_back(el);
    elements_queued++;
  endfunction

  // Mostly full range, with small values and the extremes mixed in.
  function automatic logic [VALUE_BITS-1:0] draw_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = VALUE_BITS'($urandom);
      2: v = VALUE_BITS'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int unsigned push_random_list(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_element(draw_value(), i == n - 1);
    return n;
  endfunction

  // Wait until every element is in and every result word is out, then let it settle.
  task automatic drain();
    while (elements_accepted != elements_queued || poly_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_list(logic [ORDER_W-1:0] order, bit write,
                               int unsigned n, logic [VALUE_BITS-1:0] v0,
                               logic [VALUE_BITS-1:0] v1);
    if (write) write_order(order);
    @(negedge clk_i);
    for (int unsigned i = 0; i < n; i++)
      push_element((i % 2 == 0) ? v0 : v1, i == n - 1);
    drain();
  endtask

  initial begin
    int unsigned phase_order[8] = '{2, 5, 3, 6, 4, 1, 0, 7};
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes at the reset order, then zero, saturation and the low orders.
    directed_list('0, 0, 1, 8'sd127, 8'sd127);
    directed_list('0, 0, 1, -8'sd128, -8'sd128);
    directed_list('0, 0, 1, 8'sd0, 8'sd0);
    directed_list('0, 0, 2, -8'sd1, 8'sd1);
    directed_list('0, 0, 4, 8'sd127, 8'sd127);
    directed_list('0, 0, 5, -8'sd128, -8'sd128);
    directed_list(3'd0, 1, 1, 8'sd5, 8'sd5);
    directed_list(3'd7, 1, 2, 8'sd3, -8'sd2);
    directed_list(3'd1, 1, 2, -8'sd128, 8'sd127);
    directed_list(3'd2, 1, 2, 8'sd127, -8'sd128);
    directed_list(3'd3, 1, 2, -8'sd7, 8'sd9);

    // Random lists over a sweep of order settings and pacing modes.
    for (int ph = 0; ph < 8; ph++) begin
      write_order(ORDER_W'(phase_order[ph]));
      @(negedge clk_i);
      src_idle_on = (ph % 3 != 2);
      sink_idle_on = (ph % 4 != 3);
      n = 0;
      while (n < 22) n += push_random_list($urandom_range(1, 12));
      drain();
    end

    // One element past the item limit sets the overflow flag.
    write_order(3'd4);
    @(negedge clk_i);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    n = push_random_list(MAX_ITEMS + 1);
    drain();

    // Back-pressure: the receiver stops while single-element lists keep coming.
    @(negedge clk_i);
    src_idle_on = 1'b0;
    hold_go = 1'b1;
    for (int i = 0; i < 12; i++) n = push_random_list(1);
    drain();

    if (mismatches == 0 && poly_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> elementary_symmetric_poly.f
src/esp_pkg.sv
src/esp_mul.sv
src/esp_div.sv
src/elementary_symmetric_poly.sv
bench/elementary_symmetric_poly_tb.sv
